### hdl/nsp_pkg.sv
// ----------------------------------------------------------------------------
// nsp_pkg
// Types, constants and the nibble table of the two-channel nibble player.
// ----------------------------------------------------------------------------
package nsp_pkg;

    localparam int ADDR_BITS_DEF = 16;
    localparam int DIVIDEND_BITS = 32;
    localparam int DIVISOR_BITS  = 16;

    localparam logic [DIVIDEND_BITS-1:0] STEP_BASE_RESET = 32'd732076;
    localparam logic [7:0]               REPEAT_FOREVER  = 8'hFF;
    localparam logic [3:0]               SILENT_NIBBLE   = 4'h8;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;
    localparam logic [1:0] OP_STOP  = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        channel;
        logic [15:0] mem_address;
        logic [7:0]  mem_byte;
        logic [1:0]  volume_shift;
        logic [15:0] start_address;
        logic [15:0] end_address;
        logic [7:0]  repeat_count;
        logic [15:0] repeat_address;
        logic        nibble_order;
        logic [15:0] period;
        logic [7:0]  scale;
    } t_in;

    typedef struct packed {
        logic signed [8:0] mixed_sample;
        logic              active_first;
        logic              active_second;
    } t_out;

    typedef struct packed {
        logic                     active;
        logic [1:0]               shift;
        logic [15:0]              address;
        logic [15:0]              end_addr;
        logic [7:0]               repeats;
        logic [15:0]              repeat_address;
        logic                     order;
        logic                     scaled;
        logic [DIVISOR_BITS-1:0]  last_period;
        logic [DIVIDEND_BITS-1:0] step;
        logic [31:0]              position;
    } t_chan;

    // 4-bit code to signed 8-bit level; code 8 is silence
    function automatic logic [7:0] nibble_map(input logic [3:0] code);
        logic [7:0] v;
        unique case (code)
            4'h0: v = 8'h81;
            4'h1: v = 8'h90;
            4'h2: v = 8'hA0;
            4'h3: v = 8'hB0;
            4'h4: v = 8'hC0;
            4'h5: v = 8'hD0;
            4'h6: v = 8'hE0;
            4'h7: v = 8'hF0;
            4'h8: v = 8'h00;
            4'h9: v = 8'h10;
            4'hA: v = 8'h20;
            4'hB: v = 8'h30;
            4'hC: v = 8'h40;
            4'hD: v = 8'h50;
            4'hE: v = 8'h60;
            4'hF: v = 8'h70;
        endcase
        return v;
    endfunction

endpackage

### hdl/nibble_sample_player_two_channel.sv
// ----------------------------------------------------------------------------
// nibble_sample_player_two_channel
// Two-channel 4-bit sample player over one single-port sample memory.
// ----------------------------------------------------------------------------
// Tick: S_TA0 and S_TA1 each read one channel through the single memory port;
//   S_TB1 registers the result and takes a new beat once the output is free.
// Write and stop finish on the input beat; so does start unless its effective
//   period changes (to nonzero): S_DIV waits for the bit-serial step divider.
// Sync reset: clears channel state, presets step base, keeps sample memory.
// ----------------------------------------------------------------------------
module nibble_sample_player_two_channel #(
    parameter int ADDR_BITS = nsp_pkg::ADDR_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  nsp_pkg::t_in                      i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output nsp_pkg::t_out                     o_out_data,
    input  logic                              i_cfg_we,
    input  logic [nsp_pkg::DIVIDEND_BITS-1:0] i_cfg_data
);
    import nsp_pkg::*;

    localparam int MEM_DEPTH = 1 << ADDR_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_TA0  = 3'd2;
    localparam logic [2:0] S_TA1  = 3'd3;
    localparam logic [2:0] S_TB1  = 3'd4;

    logic [2:0]               r_state, n_state;
    logic [DIVIDEND_BITS-1:0] r_step_base;
    t_chan                    r_ch [2];
    logic [7:0]               r_mem [MEM_DEPTH];
    logic [7:0]               r_rd;
    logic                     r_use [2];
    logic                     r_high [2];
    logic signed [7:0]        r_val0;
    logic                     r_div_ch;
    logic                     r_out_valid;
    t_out                     r_out;

    logic                     out_free, can_accept, in_acc;
    logic                     is_tick, is_write, is_start, is_stop;
    logic [2:0]               accept_next;
    logic [DIVISOR_BITS-1:0]  eff_per;
    logic                     start_ok, need_div;
    t_chan                    sel_ch, st_ch;
    logic                     a_phase, a_c;
    t_chan                    a_cur, a_next;
    logic [15:0]              a_idx;
    logic                     a_use, a_high;
    logic [31:0]              rd_wide, wr_wide;
    logic signed [7:0]        val1;
    logic signed [8:0]        mix;
    logic                     div_done;
    logic [DIVIDEND_BITS-1:0] div_q;

    function automatic logic signed [7:0] level(input logic [7:0] b, input logic hi,
                                                input logic en, input logic [1:0] sh);
        logic [3:0] code;
        code = en ? (hi ? b[7:4] : b[3:0]) : SILENT_NIBBLE;
        return $signed(nibble_map(code)) >>> sh;
    endfunction

    // handshake
    assign out_free   = !r_out_valid || !i_out_stall;
    assign can_accept = (r_state == S_IDLE) || ((r_state == S_TB1) && out_free);
    assign o_in_stall = !can_accept;
    assign in_acc     = i_in_valid && can_accept;

    assign is_tick  = (i_in_data.opcode == OP_TICK);
    assign is_write = (i_in_data.opcode == OP_WRITE);
    assign is_start = (i_in_data.opcode == OP_START);
    assign is_stop  = (i_in_data.opcode == OP_STOP);

    // start decode
    always_comb begin
        eff_per  = (i_in_data.scale >= 8'd16) ? '0 : (i_in_data.period >> i_in_data.scale[3:0]);
        sel_ch   = r_ch[i_in_data.channel];
        start_ok = (i_in_data.end_address > i_in_data.start_address);
        need_div = in_acc && is_start && start_ok && (eff_per != '0)
                   && (eff_per != sel_ch.last_period);

        st_ch          = sel_ch;
        st_ch.shift    = i_in_data.volume_shift;
        st_ch.address  = i_in_data.start_address;
        st_ch.end_addr = i_in_data.end_address;
        if (start_ok) begin
            st_ch.repeats        = i_in_data.repeat_count;
            st_ch.repeat_address = i_in_data.repeat_address;
            st_ch.order          = i_in_data.nibble_order;
            st_ch.scaled         = (i_in_data.scale != 8'd0);
            st_ch.position       = '0;
            if (eff_per == '0) begin
                st_ch.last_period = '0;
                st_ch.step        = '0;
                st_ch.active      = 1'b0;
            end else begin
                st_ch.active = 1'b1;
                // the new step arrives from the divider
                if (eff_per != sel_ch.last_period)
                    st_ch.last_period = eff_per;
            end
        end
    end

    // address phase of a tick: end, repeat and stop handling, then the fetch
    assign a_phase = (r_state == S_TA0) || (r_state == S_TA1);
    assign a_c     = (r_state == S_TA1);
    assign a_cur   = r_ch[a_c];

    always_comb begin
        logic [15:0] idx0;
        logic [31:0] pos;
        logic        silent;
        idx0   = a_cur.position[31:16] + a_cur.address;
        pos    = a_cur.position;
        silent = 1'b0;
        a_next = a_cur;
        a_idx  = idx0;
        if (idx0 >= a_cur.end_addr) begin
            if ((a_cur.repeats != REPEAT_FOREVER) && (a_cur.repeats == 8'd0)) begin
                silent = 1'b1;
            end else begin
                if (a_cur.repeats != REPEAT_FOREVER)
                    a_next.repeats = a_cur.repeats - 8'd1;
                a_next.address = a_cur.repeat_address;
                pos            = '0;
                a_idx          = a_cur.repeat_address;
                if (a_cur.repeat_address >= a_cur.end_addr)
                    silent = 1'b1;
            end
        end
        a_high = a_cur.scaled ? a_cur.order : (pos[15] ^ a_cur.order);
        if (silent) begin
            a_next.active   = 1'b0;
            a_next.position = pos;
        end else begin
            a_next.position = pos + a_cur.step;
        end
        a_use = a_cur.active && !silent;
        if (!a_cur.active)
            a_next = a_cur;
    end

    assign rd_wide = {16'd0, a_idx};
    assign wr_wide = {16'd0, i_in_data.mem_address};

    // sample memory: one port, writes on the input beat, reads in address phases
    always_ff @(posedge i_clk) begin
        if (in_acc && is_write)
            r_mem[wr_wide[ADDR_BITS-1:0]] <= i_in_data.mem_byte;
        if (a_phase)
            r_rd <= r_mem[rd_wide[ADDR_BITS-1:0]];
    end

    assign val1 = level(r_rd, r_high[1], r_use[1], r_ch[1].shift);
    assign mix  = {r_val0[7], r_val0} + {val1[7], val1};

    always_ff @(posedge i_clk) begin
        if (a_phase) begin
            r_use[a_c]  <= a_use;
            r_high[a_c] <= a_high;
        end
        // capture the first channel before its read data is overwritten
        if (r_state == S_TA1)
            r_val0 <= level(r_rd, r_high[0], r_use[0], r_ch[0].shift);
        if (need_div)
            r_div_ch <= i_in_data.channel;
        if ((r_state == S_TB1) && out_free) begin
            r_out.mixed_sample  <= mix;
            r_out.active_first  <= r_ch[0].active;
            r_out.active_second <= r_ch[1].active;
        end
    end

    nsp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (need_div),
        .i_dividend (r_step_base),
        .i_divisor  (eff_per),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_comb begin
        priority if (is_tick) accept_next = S_TA0;
        else if (need_div)    accept_next = S_DIV;
        else                  accept_next = S_IDLE;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc) n_state = accept_next;
            S_DIV:  if (div_done) n_state = S_IDLE;
            S_TA0:  n_state = S_TA1;
            S_TA1:  n_state = S_TB1;
            S_TB1:  if (out_free) n_state = in_acc ? accept_next : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step_base <= STEP_BASE_RESET;
            r_out_valid <= 1'b0;
            r_ch[0]     <= '0;
            r_ch[1]     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we)
                r_step_base <= i_cfg_data;
            if ((r_state == S_TB1) && out_free)
                r_out_valid <= 1'b1;
            else if (!i_out_stall)
                r_out_valid <= 1'b0;
            if (a_phase)
                r_ch[a_c] <= a_next;
            if (in_acc && is_start)
                r_ch[i_in_data.channel] <= st_ch;
            if (in_acc && is_stop)
                r_ch[i_in_data.channel].active <= 1'b0;
            if (div_done)
                r_ch[r_div_ch].step <= div_q;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### hdl/nsp_div.sv
// ----------------------------------------------------------------------------
// nsp_div
// Restoring unsigned divider, one quotient bit per cycle, for the step value.
// ----------------------------------------------------------------------------
module nsp_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [nsp_pkg::DIVIDEND_BITS-1:0] i_dividend,
    input  logic [nsp_pkg::DIVISOR_BITS-1:0]  i_divisor,
    output logic                              o_done,
    output logic [nsp_pkg::DIVIDEND_BITS-1:0] o_quotient
);
    import nsp_pkg::*;

    localparam int CNT_BITS = $clog2(DIVIDEND_BITS);

    logic                     r_busy;
    logic                     r_done;
    logic [CNT_BITS-1:0]      r_cnt;
    logic [DIVIDEND_BITS-1:0] r_quo;
    logic [DIVISOR_BITS-1:0]  r_rem;
    logic [DIVISOR_BITS-1:0]  r_div;

    logic [DIVISOR_BITS:0]    rem_sh;
    logic [DIVISOR_BITS:0]    rem_sub;
    logic                     take;
    logic [DIVISOR_BITS-1:0]  n_rem;

    always_comb begin
        rem_sh  = {r_rem, r_quo[DIVIDEND_BITS-1]};
        rem_sub = rem_sh - {1'b0, r_div};
        take    = (rem_sh >= {1'b0, r_div});
        n_rem   = take ? rem_sub[DIVISOR_BITS-1:0] : rem_sh[DIVISOR_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(DIVIDEND_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVIDEND_BITS-2:0], take};
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
